// File: sv/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// types, widths and helpers shared by the look-at view matrix pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package lav_pkg;

    localparam int IN_W     = 16;
    localparam int FRAC     = 14;
    localparam int OUT_W    = FRAC + 2;
    localparam int NIN_W    = 34;          // signed vector entering a normaliser
    localparam int MAG_W    = NIN_W;       // magnitude of such a component
    localparam int SH_W     = 6;           // leading-one position 0..MAG_W-1
    localparam int W_W      = 30;          // normalised magnitude, top bit at 29
    localparam int NORM_TOP = W_W - 1;
    localparam int SQ_W     = 2 * W_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = W_W + 1;
    localparam int TRY_W    = 64;
    localparam int NUM_W    = W_W + FRAC + 1;
    localparam int Q_W      = FRAC + 1;
    localparam int SIDE_W   = 6 * OUT_W;
    localparam int PROD_W   = 2 * OUT_W;

    typedef logic signed [IN_W-1:0]  lav_in_coord_t;
    typedef logic signed [OUT_W-1:0] lav_unit_t;
    typedef logic signed [NIN_W-1:0] lav_wide_t;

    typedef struct packed {
        lav_in_coord_t eye_x;
        lav_in_coord_t eye_y;
        lav_in_coord_t eye_z;
        lav_in_coord_t center_x;
        lav_in_coord_t center_y;
        lav_in_coord_t center_z;
        lav_in_coord_t up_x;
        lav_in_coord_t up_y;
        lav_in_coord_t up_z;
    } lav_in_t;

    typedef struct packed {
        lav_unit_t side_x;
        lav_unit_t side_y;
        lav_unit_t side_z;
        lav_unit_t true_up_x;
        lav_unit_t true_up_y;
        lav_unit_t true_up_z;
        lav_unit_t back_x;
        lav_unit_t back_y;
        lav_unit_t back_z;
        logic      degenerate;
    } lav_out_t;

    // request entering a normaliser
    typedef struct packed {
        logic               ok;
        logic [SIDE_W-1:0]  side;
        lav_wide_t [2:0]    v;
    } lav_nin_t;

    // unit vector leaving a normaliser
    typedef struct packed {
        logic               ok;
        logic [SIDE_W-1:0]  side;
        lav_unit_t [2:0]    u;
    } lav_nout_t;

    typedef struct packed {
        logic               ok;
        logic [2:0]         neg;
        logic [SIDE_W-1:0]  side;
    } lav_tag_t;

    function automatic logic [SH_W-1:0] lead_pos(input logic [MAG_W-1:0] x);
        logic [SH_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (x[i])
            begin
                p = SH_W'(i);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// File: sv/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// view rotation rows side, true up and back from eye, target and up vectors
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high and busy low; busy
// is high only while reset is applied and until the first clock edge after
// its release, so one request per cycle is accepted back to back.
// Each request gives one result on the result port, marked by done for a
// single cycle. The receiver cannot hold results off and the pipeline never
// stalls.
// Latency is set by three chained normalisers of 53 stages each (31 root
// stages and 15 divide stages dominate), the two cross product stage pairs
// and the input and output registers.
// When the eye equals the target, or up is parallel to the view or zero,
// the result rows are zero and degenerate is set.
// Reset clears every valid bit in the pipeline; requests in flight are lost
// and no result appears for them.
`default_nettype none

module look_at_view_matrix (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire lav_pkg::lav_in_t  req,
    output logic                   done,
    output lav_pkg::lav_out_t      result
);
    import lav_pkg::*;

    logic       busy_reg;
    logic       acc;

    logic       v0_reg;
    lav_nin_t   n1_in_reg;

    logic       n1_v;
    lav_nout_t  n1_out;
    logic       p1_v_reg;
    lav_nout_t  p1_f_reg;
    logic signed [PROD_W-1:0] p1_reg [0:5];
    logic       d1_v_reg;
    lav_nin_t   n2_in_reg;

    logic       n2_v;
    lav_nout_t  n2_out;
    logic       p2_v_reg;
    lav_nout_t  p2_s_reg;
    logic signed [PROD_W-1:0] p2_reg [0:5];
    logic       d2_v_reg;
    lav_nin_t   n3_in_reg;

    logic       n3_v;
    lav_nout_t  n3_out;
    logic       done_reg;
    lav_out_t   result_reg;

    lav_unit_t [2:0] up1;
    lav_unit_t [2:0] f1;
    lav_unit_t [2:0] s2;
    lav_unit_t [2:0] f2;
    lav_unit_t [2:0] s3;
    lav_unit_t [2:0] f3;

    assign acc = start & ~busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            v0_reg   <= 1'b0;
            p1_v_reg <= 1'b0;
            d1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            d2_v_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            v0_reg   <= acc;
            p1_v_reg <= n1_v;
            d1_v_reg <= p1_v_reg;
            p2_v_reg <= n2_v;
            d2_v_reg <= p2_v_reg;
            done_reg <= n3_v;
        end
    end

    // forward direction, up rides along for the first cross product
    // vectors are held with x in the top lane
    always_ff @(posedge clk)
    begin
        n1_in_reg.ok   <= 1'b1;
        n1_in_reg.side <= SIDE_W'({OUT_W'(req.up_x), OUT_W'(req.up_y), OUT_W'(req.up_z)});
        n1_in_reg.v[2] <= NIN_W'(req.center_x) - NIN_W'(req.eye_x);
        n1_in_reg.v[1] <= NIN_W'(req.center_y) - NIN_W'(req.eye_y);
        n1_in_reg.v[0] <= NIN_W'(req.center_z) - NIN_W'(req.eye_z);
    end

    lav_norm u_norm_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_req    (n1_in_reg),
        .out_valid (n1_v),
        .out_res   (n1_out)
    );

    assign f1  = n1_out.u;
    assign up1 = n1_out.side[3*OUT_W-1:0];

    // side = f x up
    always_ff @(posedge clk)
    begin
        p1_f_reg <= n1_out;
        p1_reg[0] <= f1[1] * up1[0];
        p1_reg[1] <= f1[0] * up1[1];
        p1_reg[2] <= f1[0] * up1[2];
        p1_reg[3] <= f1[2] * up1[0];
        p1_reg[4] <= f1[2] * up1[1];
        p1_reg[5] <= f1[1] * up1[2];

        n2_in_reg.ok   <= p1_f_reg.ok;
        n2_in_reg.side <= SIDE_W'(p1_f_reg.u);
        n2_in_reg.v[2] <= NIN_W'(p1_reg[0]) - NIN_W'(p1_reg[1]);
        n2_in_reg.v[1] <= NIN_W'(p1_reg[2]) - NIN_W'(p1_reg[3]);
        n2_in_reg.v[0] <= NIN_W'(p1_reg[4]) - NIN_W'(p1_reg[5]);
    end

    lav_norm u_norm_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_v_reg),
        .in_req    (n2_in_reg),
        .out_valid (n2_v),
        .out_res   (n2_out)
    );

    assign s2 = n2_out.u;
    assign f2 = n2_out.side[3*OUT_W-1:0];

    // true up = s x f
    always_ff @(posedge clk)
    begin
        p2_s_reg <= n2_out;
        p2_reg[0] <= s2[1] * f2[0];
        p2_reg[1] <= s2[0] * f2[1];
        p2_reg[2] <= s2[0] * f2[2];
        p2_reg[3] <= s2[2] * f2[0];
        p2_reg[4] <= s2[2] * f2[1];
        p2_reg[5] <= s2[1] * f2[2];

        n3_in_reg.ok   <= p2_s_reg.ok;
        n3_in_reg.side <= {p2_s_reg.u, p2_s_reg.side[3*OUT_W-1:0]};
        n3_in_reg.v[2] <= NIN_W'(p2_reg[0]) - NIN_W'(p2_reg[1]);
        n3_in_reg.v[1] <= NIN_W'(p2_reg[2]) - NIN_W'(p2_reg[3]);
        n3_in_reg.v[0] <= NIN_W'(p2_reg[4]) - NIN_W'(p2_reg[5]);
    end

    lav_norm u_norm_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_v_reg),
        .in_req    (n3_in_reg),
        .out_valid (n3_v),
        .out_res   (n3_out)
    );

    assign s3 = n3_out.side[SIDE_W-1:3*OUT_W];
    assign f3 = n3_out.side[3*OUT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (n3_out.ok)
        begin
            result_reg.side_x    <= s3[2];
            result_reg.side_y    <= s3[1];
            result_reg.side_z    <= s3[0];
            result_reg.true_up_x <= n3_out.u[2];
            result_reg.true_up_y <= n3_out.u[1];
            result_reg.true_up_z <= n3_out.u[0];
            result_reg.back_x    <= -f3[2];
            result_reg.back_y    <= -f3[1];
            result_reg.back_z    <= -f3[0];
        end
        else
        begin
            result_reg.side_x    <= '0;
            result_reg.side_y    <= '0;
            result_reg.side_z    <= '0;
            result_reg.true_up_x <= '0;
            result_reg.true_up_y <= '0;
            result_reg.true_up_z <= '0;
            result_reg.back_x    <= '0;
            result_reg.back_y    <= '0;
            result_reg.back_z    <= '0;
        end
        result_reg.degenerate <= ~n3_out.ok;
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: sv/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// pipelined normaliser: scale, sum of squares, bitwise root, restoring divide
// ----------------------------------------------------------------------------
`default_nettype none

module lav_norm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire lav_pkg::lav_nin_t  in_req,
    output logic                 out_valid,
    output lav_pkg::lav_nout_t   out_res
);
    import lav_pkg::*;

    // stage 1: magnitudes
    logic                     v1_reg;
    lav_tag_t                 tag1_reg;
    logic [2:0][MAG_W-1:0]    mag1_reg;
    // stage 2: leading one
    logic                     v2_reg;
    lav_tag_t                 tag2_reg;
    logic [2:0][MAG_W-1:0]    mag2_reg;
    logic [SH_W-1:0]          pos2_reg;
    // stage 3: scaled magnitudes
    logic                     v3_reg;
    lav_tag_t                 tag3_reg;
    logic [2:0][W_W-1:0]      w3_reg;
    // stage 4: squares
    logic                     v4_reg;
    lav_tag_t                 tag4_reg;
    logic [2:0][W_W-1:0]      w4_reg;
    logic [2:0][SQ_W-1:0]     sq4_reg;

    // root stages
    logic                     sv_reg   [0:ROOT_W];
    lav_tag_t                 stag_reg [0:ROOT_W];
    logic [2:0][W_W-1:0]      sw_reg   [0:ROOT_W];
    logic [ROOT_W-1:0]        root_reg [0:ROOT_W];
    logic [SUM_W-1:0]         srem_reg [0:ROOT_W];

    // divide stages
    logic                     dv_reg   [0:Q_W];
    lav_tag_t                 dtag_reg [0:Q_W];
    logic [ROOT_W-1:0]        dlen_reg [0:Q_W];
    logic [2:0][NUM_W-1:0]    drem_reg [0:Q_W];
    logic [2:0][Q_W-1:0]      dq_reg   [0:Q_W];

    logic                     ov_reg;
    lav_nout_t                ores_reg;

    logic [MAG_W-1:0]         mag_or;
    logic [SH_W-1:0]          rshift;
    logic [SH_W-1:0]          lshift;

    function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] q);
        return (q > Q_W'(1 << FRAC)) ? Q_W'(1 << FRAC) : q;
    endfunction

    assign mag_or = mag1_reg[0] | mag1_reg[1] | mag1_reg[2];
    assign rshift = pos2_reg - SH_W'(NORM_TOP);
    assign lshift = SH_W'(NORM_TOP) - pos2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            sv_reg[0] <= 1'b0;
            dv_reg[0] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            sv_reg[0] <= v4_reg;
            dv_reg[0] <= sv_reg[ROOT_W];
            ov_reg <= dv_reg[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg.ok   <= in_req.ok;
        tag1_reg.side <= in_req.side;
        for (int i = 0; i < 3; i++)
        begin
            tag1_reg.neg[i] <= in_req.v[i][NIN_W-1];
            mag1_reg[i]     <= in_req.v[i][NIN_W-1] ? MAG_W'(-in_req.v[i])
                                                    : MAG_W'(in_req.v[i]);
        end

        tag2_reg.ok   <= tag1_reg.ok & (mag_or != '0);
        tag2_reg.neg  <= tag1_reg.neg;
        tag2_reg.side <= tag1_reg.side;
        mag2_reg      <= mag1_reg;
        pos2_reg      <= lead_pos(mag_or);

        tag3_reg <= tag2_reg;
        for (int i = 0; i < 3; i++)
        begin
            if (pos2_reg >= SH_W'(NORM_TOP))
            begin
                w3_reg[i] <= W_W'(mag2_reg[i] >> rshift);
            end
            else
            begin
                w3_reg[i] <= W_W'(mag2_reg[i] << lshift);
            end
        end

        tag4_reg <= tag3_reg;
        w4_reg   <= w3_reg;
        for (int i = 0; i < 3; i++)
        begin
            sq4_reg[i] <= w3_reg[i] * w3_reg[i];
        end

        stag_reg[0] <= tag4_reg;
        sw_reg[0]   <= w4_reg;
        root_reg[0] <= '0;
        srem_reg[0] <= SUM_W'(sq4_reg[0]) + SUM_W'(sq4_reg[1]) + SUM_W'(sq4_reg[2]);

        // numerator carries half the length so the quotient rounds
        dtag_reg[0] <= stag_reg[ROOT_W];
        dlen_reg[0] <= root_reg[ROOT_W];
        dq_reg[0]   <= '0;
        for (int i = 0; i < 3; i++)
        begin
            drem_reg[0][i] <= {1'b0, sw_reg[ROOT_W][i], FRAC'(0)}
                              + NUM_W'(root_reg[ROOT_W] >> 1);
        end

        ores_reg.ok   <= dtag_reg[Q_W].ok;
        ores_reg.side <= dtag_reg[Q_W].side;
        for (int i = 0; i < 3; i++)
        begin
            if (!dtag_reg[Q_W].ok)
            begin
                ores_reg.u[i] <= '0;
            end
            else
            begin
                ores_reg.u[i] <= dtag_reg[Q_W].neg[i]
                    ? -lav_unit_t'(sat_q(dq_reg[Q_W][i]))
                    :  lav_unit_t'(sat_q(dq_reg[Q_W][i]));
            end
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_root
        localparam int B = ROOT_W - 1 - k;
        logic [TRY_W-1:0] trial;
        logic             take;

        assign trial = (TRY_W'(root_reg[k]) << (B + 1)) + (TRY_W'(1) << (2 * B));
        assign take  = TRY_W'(srem_reg[k]) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sv_reg[k+1] <= 1'b0;
            end
            else
            begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            stag_reg[k+1] <= stag_reg[k];
            sw_reg[k+1]   <= sw_reg[k];
            if (take)
            begin
                srem_reg[k+1] <= SUM_W'(TRY_W'(srem_reg[k]) - trial);
                root_reg[k+1] <= root_reg[k] | ROOT_W'(ROOT_W'(1) << B);
            end
            else
            begin
                srem_reg[k+1] <= srem_reg[k];
                root_reg[k+1] <= root_reg[k];
            end
        end
    end

    // one quotient bit per stage on each lane
    for (genvar k = 0; k < Q_W; k++)
    begin : g_div
        localparam int B = Q_W - 1 - k;
        logic [TRY_W-1:0] dsh;

        assign dsh = TRY_W'(dlen_reg[k]) << B;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_reg[k+1] <= 1'b0;
            end
            else
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            dtag_reg[k+1] <= dtag_reg[k];
            dlen_reg[k+1] <= dlen_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if (TRY_W'(drem_reg[k][i]) >= dsh)
                begin
                    drem_reg[k+1][i] <= NUM_W'(TRY_W'(drem_reg[k][i]) - dsh);
                    dq_reg[k+1][i]   <= dq_reg[k][i] | Q_W'(Q_W'(1) << B);
                end
                else
                begin
                    drem_reg[k+1][i] <= drem_reg[k][i];
                    dq_reg[k+1][i]   <= dq_reg[k][i];
                end
            end
        end
    end

    assign out_valid = ov_reg;
    assign out_res   = ores_reg;

endmodule

`default_nettype wire

// File: sv/lav_check.sv
// ----------------------------------------------------------------------------
// lav_check
// port-level checks on request to result timing and result contents
// ----------------------------------------------------------------------------
`default_nettype none

module lav_check (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire lav_pkg::lav_in_t  req,
    input  wire logic              done,
    input  wire lav_pkg::lav_out_t result
);
    import lav_pkg::*;

    localparam int LAT = 165;

    logic [IN_W-1:0] req_unused;
    assign req_unused = req.eye_x;

    // every request yields a result at the fixed latency
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##165 done)
        else $error("result missing after request");

    // no result without a request
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without request");

    // degenerate results carry zero in side_x, true_up_y and back_z
    a_deg: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.degenerate) |->
            (result.side_x == 0 && result.true_up_y == 0 && result.back_z == 0))
        else $error("degenerate result not zero");

    // back_x and side_y stay within one
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.back_x <= 16384 && result.back_x >= -16384 &&
                  result.side_y <= 16384 && result.side_y >= -16384))
        else $error("component out of range");

endmodule

bind look_at_view_matrix lav_check u_lav_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
);

`default_nettype wire

// File: sim/tb_look_at_view_matrix.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_look_at_view_matrix
// self-checking bench for the look-at view rotation pipeline
// ----------------------------------------------------------------------------
// Requests are queued by an initial block and driven by a clocked driver with
// random gaps. A bit-exact fixed-point predictor computes the rotation rows at
// acceptance time and the monitor compares every done-marked result with the
// oldest prediction.
`default_nettype none

module tb_look_at_view_matrix;
    import lav_pkg::*;

    localparam int LATENCY   = 165;
    localparam int WDOG_MAX  = 4000;
    localparam int N_RANDOM  = 500;
    localparam longint unsigned LO_BOUND = 64'd1 << 29;
    localparam longint unsigned HI_BOUND = 64'd1 << 30;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    lav_in_t  req;
    logic     done;
    lav_out_t result;

    lav_in_t  pending_reqs[$];
    lav_out_t expected_rows[$];
    int       error_count;
    int       idle_cycles;
    bit       gaps_on;
    bit       hold_off;
    bit       feeding_done;

    look_at_view_matrix dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // integer square root, bit by bit
    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > s)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (s >= root + bitv)
            begin
                s    = s - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // normalise to Q1.FRAC; returns 0 for the zero vector
    function automatic bit normalise(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        bit              neg[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        mx  = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = v[i] < 0;
            m[i]   = neg[i] ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
            o[i] = 0;
        end
        if (mx == 0)
            return 0;
        while (mx >= HI_BOUND)
        begin
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < LO_BOUND)
        begin
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += m[i] * m[i];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC) + (len >> 1)) / len;
            if (q > (64'd1 << FRAC))
                q = 64'd1 << FRAC;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
        return 1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3],
                                   output longint c[3]);
        c[0] = a[1] * b[2] - a[2] * b[1];
        c[1] = a[2] * b[0] - a[0] * b[2];
        c[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic lav_out_t predict_rows(input lav_in_t r);
        longint   d[3];
        longint   up[3];
        longint   fn[3];
        longint   sr[3];
        longint   sn[3];
        longint   ur[3];
        longint   un[3];
        bit       ok;
        lav_out_t o;
        d[0]  = longint'(r.center_x) - longint'(r.eye_x);
        d[1]  = longint'(r.center_y) - longint'(r.eye_y);
        d[2]  = longint'(r.center_z) - longint'(r.eye_z);
        up[0] = r.up_x;
        up[1] = r.up_y;
        up[2] = r.up_z;
        ok = normalise(d, fn);
        if (ok)
        begin
            cross3(fn, up, sr);
            ok = normalise(sr, sn);
        end
        if (ok)
        begin
            cross3(sn, fn, ur);
            ok = normalise(ur, un);
        end
        o = '0;
        if (ok)
        begin
            o.side_x    = lav_unit_t'(sn[0]);
            o.side_y    = lav_unit_t'(sn[1]);
            o.side_z    = lav_unit_t'(sn[2]);
            o.true_up_x = lav_unit_t'(un[0]);
            o.true_up_y = lav_unit_t'(un[1]);
            o.true_up_z = lav_unit_t'(un[2]);
            o.back_x    = lav_unit_t'(-fn[0]);
            o.back_y    = lav_unit_t'(-fn[1]);
            o.back_z    = lav_unit_t'(-fn[2]);
        end
        o.degenerate = !ok;
        return o;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
        error_count++;
    endtask

    function automatic lav_in_t make_req(input int ex, ey, ez, cx, cy, cz, ux, uy, uz);
        lav_in_t r;
        r.eye_x    = lav_in_coord_t'(ex);
        r.eye_y    = lav_in_coord_t'(ey);
        r.eye_z    = lav_in_coord_t'(ez);
        r.center_x = lav_in_coord_t'(cx);
        r.center_y = lav_in_coord_t'(cy);
        r.center_z = lav_in_coord_t'(cz);
        r.up_x     = lav_in_coord_t'(ux);
        r.up_y     = lav_in_coord_t'(uy);
        r.up_z     = lav_in_coord_t'(uz);
        return r;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32767 : -32768;
            1:       return int'($urandom_range(0, 16)) - 8;
            2:       return int'($urandom_range(0, 1024)) - 512;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // stimulus
    initial
    begin
        int ex, ey, ez, dx, dy, dz;
        int k;
        pending_reqs.push_back(make_req(0, 0, 256, 0, 0, 0, 0, 256, 0));
        pending_reqs.push_back(make_req(-32768, -32768, -32768, 32767, 32767, 32767,
                                        0, 256, 0));
        pending_reqs.push_back(make_req(32767, 32767, 32767, -32768, -32768, -32768,
                                        -32768, 32767, -32768));
        pending_reqs.push_back(make_req(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767));
        pending_reqs.push_back(make_req(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 1, 0, 0, -32768));
        // eye equals target
        pending_reqs.push_back(make_req(100, -200, 300, 100, -200, 300, 0, 256, 0));
        pending_reqs.push_back(make_req(-32768, -32768, -32768, -32768, -32768, -32768,
                                        32767, 32767, 32767));
        // up parallel to the view
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, -256, 0, 0, 512));
        pending_reqs.push_back(make_req(0, 0, 0, 300, 300, 300, -7, -7, -7));
        // up zero
        pending_reqs.push_back(make_req(10, 20, 30, 40, 50, 60, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 1, 1, 1, 1, 0, 0));
        pending_reqs.push_back(make_req(-1, -1, -1, 0, 0, 0, 32767, -32768, 1));
        pending_reqs.push_back(make_req(12345, -23456, 7777, -30000, 29999, -5,
                                        -32768, -32768, 32767));
        pending_reqs.push_back(make_req(32767, 0, 0, 32766, 0, 0, 0, -1, 0));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            // let the pipe drain once, mid run
            if (i == N_RANDOM / 2)
            begin
                wait (pending_reqs.size() == 0);
                hold_off = 1'b1;
                wait (expected_rows.size() == 0);
                @(posedge clk);
                hold_off = 1'b0;
            end
            ex = rand_coord();
            ey = rand_coord();
            ez = rand_coord();
            k  = $urandom_range(0, 19);
            if (k == 0)
                pending_reqs.push_back(make_req(ex, ey, ez, ex, ey, ez,
                                                rand_coord(), rand_coord(), rand_coord()));
            else if (k == 1)
            begin
                dx = int'($urandom_range(0, 64)) - 32;
                dy = int'($urandom_range(0, 64)) - 32;
                dz = int'($urandom_range(0, 64)) - 32;
                pending_reqs.push_back(make_req(ex, ey, ez, ex + dx, ey + dy, ez + dz,
                                                dx * 3, dy * 3, dz * 3));
            end
            else
                pending_reqs.push_back(make_req(ex, ey, ez, rand_coord(), rand_coord(),
                                                rand_coord(), rand_coord(), rand_coord(),
                                                rand_coord()));
        end
        feeding_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        start        = 1'b0;
        req          = '0;
        error_count  = 0;
        idle_cycles  = 0;
        gaps_on      = 1'b1;
        hold_off     = 1'b0;
        feeding_done = 1'b0;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_rows.push_back(predict_rows(req));
            if (start && busy)
            begin
                // request still offered
            end
            else if (pending_reqs.size() > 0 && !hold_off
                     && !(gaps_on && $urandom_range(0, 99) < 35))
            begin
                start <= 1'b1;
                req   <= pending_reqs.pop_front();
            end
            else
            begin
                start <= 1'b0;
                req   <= '0;
            end
            // long gap-free stretch in the random part
            gaps_on <= !(pending_reqs.size() > 150 && pending_reqs.size() < 300);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        lav_out_t want;
        if (rst_n && done)
        begin
            if (expected_rows.size() == 0)
            begin
                report_mismatch("done", 1, 0);
            end
            else
            begin
                want = expected_rows.pop_front();
                if (result.side_x !== want.side_x)
                    report_mismatch("side_x", result.side_x, want.side_x);
                if (result.side_y !== want.side_y)
                    report_mismatch("side_y", result.side_y, want.side_y);
                if (result.side_z !== want.side_z)
                    report_mismatch("side_z", result.side_z, want.side_z);
                if (result.true_up_x !== want.true_up_x)
                    report_mismatch("true_up_x", result.true_up_x, want.true_up_x);
                if (result.true_up_y !== want.true_up_y)
                    report_mismatch("true_up_y", result.true_up_y, want.true_up_y);
                if (result.true_up_z !== want.true_up_z)
                    report_mismatch("true_up_z", result.true_up_z, want.true_up_z);
                if (result.back_x !== want.back_x)
                    report_mismatch("back_x", result.back_x, want.back_x);
                if (result.back_y !== want.back_y)
                    report_mismatch("back_y", result.back_y, want.back_y);
                if (result.back_z !== want.back_z)
                    report_mismatch("back_z", result.back_z, want.back_z);
                if (result.degenerate !== want.degenerate)
                    report_mismatch("degenerate", result.degenerate, want.degenerate);
            end
        end
    end

    // watchdog on cycles with nothing accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // end of run
    initial
    begin
        wait (feeding_done && pending_reqs.size() == 0);
        @(posedge clk);
        while (start || expected_rows.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0 && expected_rows.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
